[src/fps_pkg.sv]
// fps_pkg: shared types and codes for the frame presentation scheduler.
// No dependencies; used by fps_ctrl, fps_dp and frame_presentation_scheduler in src.
`default_nettype none
package fps_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_RATE  = 1'b1;

  localparam logic [2:0] REQ_PUT   = 3'd0;
  localparam logic [2:0] REQ_TICK  = 3'd1;
  localparam logic [2:0] REQ_TAKE  = 3'd2;
  localparam logic [2:0] REQ_FLUSH = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] stamp;
    logic [31:0] addr;
  } fps_frame_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic mul_next;
    logic mul_load;
    logic div_start;
    logic now_load;
    logic nxt_load;
    logic put;
    logic drop;
    logic show;
    logic take;
    logic flush_s0;
    logic flush_s1;
    logic flush_pend;
    logic tick_inc;
    logic cnt_clr;
    logic out_load;
  } fps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] req;
    logic       div_busy;
    logic       pend_empty;
    logic       head_late;
    logic       head_due;
    logic       out_busy;
  } fps_sts_t;

endpackage
`default_nettype wire

[src/fps_if.sv]
// fps_in_if / fps_out_if: valid-ready channels for requests and results.
// Depends on nothing.
`default_nettype none
interface fps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] frame_id;
  logic [31:0] frame_time;
  logic [31:0] frame_address;
  modport source (output valid, req_type, frame_id, frame_time, frame_address, input ready);
  modport sink   (input valid, req_type, frame_id, frame_time, frame_address, output ready);
endinterface

interface fps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        shown;
  logic [15:0] out_frame_id;
  logic [31:0] out_frame_time;
  logic [31:0] out_frame_address;
  logic [31:0] ref_time;
  modport source (output valid, status, shown, out_frame_id, out_frame_time,
                  out_frame_address, ref_time, input ready);
  modport sink   (input valid, status, shown, out_frame_id, out_frame_time,
                  out_frame_address, ref_time, output ready);
endinterface
`default_nettype wire

[src/fps_div.sv]
// fps_div: restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Keeps the low 32 quotient bits. No package dependency.
`default_nettype none
module fps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quot
);
  logic [63:0] dq_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_nxt;

  assign rem_sh  = {rem_r, dq_r[63]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd0;
      dq_r   <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[62:0], ge};
      rem_r <= rem_nxt[31:0];
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quot = dq_r[31:0];
endmodule
`default_nettype wire

[src/fps_ctrl.sv]
// fps_ctrl: sequencer for the frame presentation scheduler.
// Uses fps_pkg command/status structs; drives fps_dp.
`default_nettype none
module fps_ctrl
  import fps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fps_sts_t sts,
  output fps_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_WAIT, S_DISP, S_NMUL, S_NDIV, S_NWAIT,
    S_TK_RD, S_TK_CHK, S_TK_END, S_FL_S1, S_FL_RD, S_FL_WALK, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.accept = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: if (!sts.div_busy) begin
        cmd.now_load = 1'b1;
        state_nxt    = S_DISP;
      end
      S_DISP: begin
        unique case (sts.req)
          REQ_PUT: begin
            cmd.put   = 1'b1;
            state_nxt = S_FIN;
          end
          REQ_TICK: state_nxt = S_NMUL;
          REQ_TAKE: begin
            cmd.take  = 1'b1;
            state_nxt = S_FIN;
          end
          REQ_FLUSH: begin
            cmd.flush_s0 = 1'b1;
            state_nxt    = S_FL_S1;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_NMUL: begin
        cmd.mul_next = 1'b1;
        cmd.mul_load = 1'b1;
        state_nxt    = S_NDIV;
      end
      S_NDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_NWAIT;
      end
      S_NWAIT: if (!sts.div_busy) begin
        cmd.nxt_load = 1'b1;
        state_nxt    = S_TK_RD;
      end
      S_TK_RD: state_nxt = S_TK_CHK;
      S_TK_CHK: begin
        if (sts.pend_empty) begin
          state_nxt = S_TK_END;
        end else if (sts.head_late) begin
          cmd.drop  = 1'b1;
          state_nxt = S_TK_RD;
        end else if (sts.head_due) begin
          cmd.show  = 1'b1;
          state_nxt = S_TK_END;
        end else begin
          state_nxt = S_TK_END;
        end
      end
      S_TK_END: begin
        cmd.tick_inc = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FL_S1: begin
        cmd.flush_s1 = 1'b1;
        state_nxt    = S_FL_RD;
      end
      S_FL_RD: state_nxt = S_FL_WALK;
      S_FL_WALK: begin
        if (sts.pend_empty) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.flush_pend = 1'b1;
          state_nxt      = S_FL_RD;
        end
      end
      S_FIN: if (!sts.out_busy) begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
endmodule
`default_nettype wire

[src/fps_dp.sv]
// fps_dp: datapath - config, vsync count, multiplier, divider, pending/done
// memories, shown slots and result register. Uses fps_pkg and fps_div.
`default_nettype none
module fps_dp
  import fps_pkg::*;
#(
  parameter int FRAMES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [2:0]           req_type,
  input  logic [15:0]          frame_id,
  input  logic [31:0]          frame_time,
  input  logic [31:0]          frame_address,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           status,
  output logic                 shown,
  output logic [15:0]          out_frame_id,
  output logic [31:0]          out_frame_time,
  output logic [31:0]          out_frame_address,
  output logic [31:0]          ref_time,
  input  fps_cmd_t             cmd,
  output fps_sts_t             sts
);
  localparam int PTR_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FRAMES - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  logic [31:0] scale_r, rate_r, count_r, now_r, nxt_r;
  logic [31:0] mul_arg;
  logic [63:0] prod_r;
  logic [2:0]  req_r;
  fps_frame_t  in_r;
  logic        div_busy;
  logic [31:0] quot, quot_fix;
  logic [31:0] late_diff, due_diff;

  fps_frame_t pend_mem [FRAMES];
  fps_frame_t done_mem [FRAMES];
  fps_frame_t pend_rd_r, done_rd_r;
  logic [PTR_W-1:0] pend_head_r, pend_tail_r, done_head_r, done_tail_r;
  logic [CNT_W-1:0] pend_cnt_r, done_cnt_r;
  fps_frame_t slot_r [2];
  logic [1:0] slot_valid_r;
  logic [CNT_W:0] held;
  logic full;

  fps_frame_t res_r;
  logic [1:0] res_status_r;
  logic       res_shown_r;
  fps_frame_t out_r;
  logic [1:0] out_status_r;
  logic       out_shown_r;
  logic [31:0] out_ref_r;
  logic        out_valid_r;

  logic pend_pop, pend_push, done_pop, done_push;
  fps_frame_t done_wdata;

  // config and request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
      rate_r  <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_SCALE: scale_r <= cfg_wdata;
        CFG_PIXEL_RATE:  rate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next count wraps at 32 bits before the multiply
  assign mul_arg = cmd.mul_next ? count_r + 32'd1 : count_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r       <= req_type;
      in_r.id     <= frame_id;
      in_r.stamp  <= frame_time;
      in_r.addr   <= frame_address;
    end
    if (cmd.mul_load)
      prod_r <= {32'd0, mul_arg} * {32'd0, scale_r};
    if (cmd.now_load) now_r <= quot_fix;
    if (cmd.nxt_load) nxt_r <= quot_fix;
  end

  fps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(prod_r),
    .divisor(rate_r), .busy(div_busy), .quot(quot)
  );
  assign quot_fix = (rate_r == 32'd0) ? 32'hFFFF_FFFF : quot;

  always_ff @(posedge clk) begin
    if (!rst_n)            count_r <= '0;
    else if (cmd.cnt_clr)  count_r <= '0;
    else if (cmd.tick_inc) count_r <= count_r + 32'd1;
  end

  // queue control
  assign held = {1'b0, pend_cnt_r} + {1'b0, done_cnt_r}
              + (CNT_W+1)'(slot_valid_r[0]) + (CNT_W+1)'(slot_valid_r[1]);
  assign full = held >= (CNT_W+1)'(FRAMES);

  assign pend_push = cmd.put && !full;
  assign pend_pop  = cmd.drop || cmd.show || cmd.flush_pend;
  assign done_pop  = cmd.take && (done_cnt_r != '0);
  assign done_push = cmd.drop || cmd.flush_pend || (cmd.show && slot_valid_r[0])
                   || (cmd.flush_s0 && slot_valid_r[0]) || (cmd.flush_s1 && slot_valid_r[1]);

  always_comb begin
    if (cmd.drop || cmd.flush_pend) done_wdata = pend_rd_r;
    else if (cmd.flush_s1)          done_wdata = slot_r[1];
    else                            done_wdata = slot_r[0];
  end

  always_ff @(posedge clk) begin
    if (pend_push) pend_mem[pend_tail_r] <= in_r;
    pend_rd_r <= pend_mem[pend_head_r];
  end

  always_ff @(posedge clk) begin
    if (done_push) done_mem[done_tail_r] <= done_wdata;
    done_rd_r <= done_mem[done_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_head_r  <= '0;
      pend_tail_r  <= '0;
      pend_cnt_r   <= '0;
      done_head_r  <= '0;
      done_tail_r  <= '0;
      done_cnt_r   <= '0;
      slot_valid_r <= '0;
    end else begin
      if (pend_push) pend_tail_r <= ptr_inc(pend_tail_r);
      if (pend_pop)  pend_head_r <= ptr_inc(pend_head_r);
      if (pend_push && !pend_pop)      pend_cnt_r <= pend_cnt_r + 1'b1;
      else if (pend_pop && !pend_push) pend_cnt_r <= pend_cnt_r - 1'b1;
      if (done_push) done_tail_r <= ptr_inc(done_tail_r);
      if (done_pop)  done_head_r <= ptr_inc(done_head_r);
      if (done_push && !done_pop)      done_cnt_r <= done_cnt_r + 1'b1;
      else if (done_pop && !done_push) done_cnt_r <= done_cnt_r - 1'b1;
      if (cmd.show)     slot_valid_r <= {1'b1, slot_valid_r[1]};
      if (cmd.flush_s0) slot_valid_r[0] <= 1'b0;
      if (cmd.flush_s1) slot_valid_r[1] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= pend_rd_r;
    end
  end

  // result build and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_r        <= '0;
      res_status_r <= ST_OK;
      res_shown_r  <= 1'b0;
    end else begin
      if (cmd.put && full) res_status_r <= ST_FULL;
      if (cmd.take) begin
        if (done_cnt_r == '0) res_status_r <= ST_EMPTY;
        else                  res_r        <= done_rd_r;
      end
      if (cmd.show) begin
        res_r       <= pend_rd_r;
        res_shown_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_r        <= res_r;
      out_status_r <= res_status_r;
      out_shown_r  <= res_shown_r;
      out_ref_r    <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  assign out_valid         = out_valid_r;
  assign status            = out_status_r;
  assign shown             = out_shown_r;
  assign out_frame_id      = out_r.id;
  assign out_frame_time    = out_r.stamp;
  assign out_frame_address = out_r.addr;
  assign ref_time          = out_ref_r;

  // wrap-safe compare: head stamp before now / before next tick's time
  assign late_diff = pend_rd_r.stamp - now_r;
  assign due_diff  = pend_rd_r.stamp - nxt_r;

  assign sts.req        = req_r;
  assign sts.div_busy   = div_busy;
  assign sts.pend_empty = (pend_cnt_r == '0);
  assign sts.head_late  = late_diff[31];
  assign sts.head_due   = due_diff[31];
  assign sts.out_busy   = out_valid_r && !out_ready;

`ifndef ASSERT_OFF
  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held <= (CNT_W+1)'(FRAMES)) else $error("more frames held than store holds");
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    slot_valid_r[0] |-> slot_valid_r[1]) else $error("slot 0 valid without slot 1");
  a_show_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.show |-> pend_cnt_r != '0) else $error("show with empty pending queue");
`endif
endmodule
`default_nettype wire

[src/frame_presentation_scheduler.sv]
// One item at a time: every request runs a multiply and a divide for the reference
// time, a vsync tick runs a second pair for the next tick's time and then walks the
// late frames it drops, and a flush walks every pending frame. The divider run sets
// the pace. The result register frees the input side at once.
// Reset (synchronous, rst_n low): queues and slots empty, vsync count 0,
// frame_scale 0, pixel_rate 1. Frame memories are not cleared.
`default_nettype none
module frame_presentation_scheduler
  import fps_pkg::*;
#(
  parameter int FRAMES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  fps_in_if.sink               in_ch,
  fps_out_if.source            out_ch
);
  fps_cmd_t cmd;
  fps_sts_t sts;

  // controller: sequences multiply, divide, queue walk and result load
  fps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  // datapath: all storage and arithmetic
  fps_dp #(.FRAMES(FRAMES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .req_type(in_ch.req_type), .frame_id(in_ch.frame_id),
    .frame_time(in_ch.frame_time), .frame_address(in_ch.frame_address),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .status(out_ch.status), .shown(out_ch.shown),
    .out_frame_id(out_ch.out_frame_id), .out_frame_time(out_ch.out_frame_time),
    .out_frame_address(out_ch.out_frame_address), .ref_time(out_ch.ref_time),
    .cmd(cmd), .sts(sts)
  );
endmodule
`default_nettype wire

[tb/sv/fps_tb_pkg.sv]
// fps_tb_pkg: request and result records used by the scheduler testbench.
// Imports fps_pkg; its records declare their own fields.
`default_nettype none
package fps_tb_pkg;
  import fps_pkg::*;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] id;
    logic [31:0] stamp;
    logic [31:0] addr;
  } fps_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        shown;
    logic [15:0] id;
    logic [31:0] stamp;
    logic [31:0] addr;
    logic [31:0] ref_time;
  } fps_result_t;
endpackage
`default_nettype wire

[tb/sv/testbench.sv]
// testbench: self-checking bench for frame_presentation_scheduler.
// Depends on fps_pkg, fps_tb_pkg, fps_if and the scheduler RTL; it predicts
// each result with a behavioral copy of the scheduler and compares in order.
`default_nettype none
module testbench;
  import fps_pkg::*;
  import fps_tb_pkg::*;

  localparam int FRAMES = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  fps_in_if  in_ch ();
  fps_out_if out_ch ();

  frame_presentation_scheduler #(.FRAMES(FRAMES)) i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // Scheduler model state
  logic [31:0] scale_m, rate_m, vcount_m;
  fps_frame_t  pend_q[$];
  fps_frame_t  done_q[$];
  fps_frame_t  slot_m[2];
  logic [1:0]  slot_ok_m;

  fps_result_t expected_q[$];
  int  mismatch_cnt = 0;
  int  idle_cnt = 0;
  bit  sink_stall_en = 1'b1;
  bit  src_gap_en = 1'b1;

  function automatic logic [31:0] ref_time_at(logic [31:0] count);
    logic [63:0] prod;
    prod = {32'd0, count} * {32'd0, scale_m};
    if (rate_m == 0) return 32'hFFFF_FFFF;
    return 32'(prod / {32'd0, rate_m});
  endfunction

  // wrap-safe "a lies before b"
  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic fps_result_t schedule_step(fps_req_t r);
    fps_result_t res;
    fps_frame_t  f;
    logic [31:0] nxt;
    res = '0;
    res.ref_time = ref_time_at(vcount_m);
    case (r.req)
      REQ_PUT: begin
        if (pend_q.size() + done_q.size() + slot_ok_m[0] + slot_ok_m[1] >= FRAMES) begin
          res.status = ST_FULL;
        end else begin
          f.id = r.id; f.stamp = r.stamp; f.addr = r.addr;
          pend_q.push_back(f);
        end
      end
      REQ_TICK: begin
        nxt = ref_time_at(vcount_m + 32'd1);
        while (pend_q.size() != 0) begin
          if (earlier(pend_q[0].stamp, res.ref_time)) begin
            done_q.push_back(pend_q.pop_front());   // late: drop to done
          end else if (earlier(pend_q[0].stamp, nxt)) begin
            f = pend_q.pop_front();
            if (slot_ok_m[0]) done_q.push_back(slot_m[0]);
            slot_m[0] = slot_m[1];
            slot_ok_m[0] = slot_ok_m[1];
            slot_m[1] = f;
            slot_ok_m[1] = 1'b1;
            res.shown = 1'b1;
            res.id = f.id; res.stamp = f.stamp; res.addr = f.addr;
            break;
          end else begin
            break;
          end
        end
        vcount_m = vcount_m + 32'd1;
      end
      REQ_TAKE: begin
        if (done_q.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          f = done_q.pop_front();
          res.id = f.id; res.stamp = f.stamp; res.addr = f.addr;
        end
      end
      REQ_FLUSH: begin
        for (int s = 0; s < 2; s++) begin
          if (slot_ok_m[s]) done_q.push_back(slot_m[s]);
        end
        slot_ok_m = '0;
        while (pend_q.size() != 0) done_q.push_back(pend_q.pop_front());
        vcount_m = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Input side: valid/ready, bursts of idle between items. Valid stays up
  // after an accept until the next item or an idle stretch replaces it.
  task automatic send_item(fps_req_t r);
    int gap;
    if (src_gap_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= r.req;
    in_ch.frame_id      <= r.id;
    in_ch.frame_time    <= r.stamp;
    in_ch.frame_address <= r.addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(schedule_step(r));
  endtask

  task automatic send_req(logic [2:0] req, logic [15:0] id = '0,
                          logic [31:0] stamp = '0, logic [31:0] addr = '0);
    fps_req_t r;
    r.req = req; r.id = id; r.stamp = stamp; r.addr = addr;
    send_item(r);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);   // covers a tick walking a full pending list
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_SCALE) scale_m = val;
    else rate_m = val;
  endtask

  // Result side: random stall bursts, in-order compare
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          fps_result_t e;
          fps_result_t a;
          e = expected_q.pop_front();
          a = '{out_ch.status, out_ch.shown, out_ch.out_frame_id, out_ch.out_frame_time,
                out_ch.out_frame_address, out_ch.ref_time};
          if (a !== e) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp st=%0d sh=%0d id=%h t=%h a=%h ref=%h",
                       e.status, e.shown, e.id, e.stamp, e.addr, e.ref_time,
                       " got st=%0d sh=%0d id=%h t=%h a=%h ref=%h",
                       a.status, a.shown, a.id, a.stamp, a.addr, a.ref_time);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (rst_n && (in_ch.valid || expected_q.size() != 0)) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---- tests ----

  // Field extremes, every request type, full store, empty take, unknown codes
  task automatic test_directed();
    write_reg(CFG_FRAME_SCALE, 32'd100);
    write_reg(CFG_PIXEL_RATE, 32'd10);     // ref advances by 10 per tick
    send_req(REQ_TAKE);                    // empty done queue
    send_req(REQ_READ);
    send_req(REQ_PUT, 16'hFFFF, 32'd5, 32'hFFFF_FFFF);     // due on first tick
    send_req(REQ_PUT, 16'h0000, 32'd0, 32'h0000_0000);
    send_req(REQ_PUT, 16'h1234, 32'hFFFF_FFFF, 32'hA5A5_5A5A); // wraps: late
    send_req(REQ_TICK);
    send_req(REQ_TICK);
    send_req(REQ_TICK);
    send_req(3'd5);
    send_req(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < FRAMES + 1; i++)                  // fill, then refuse
      send_req(REQ_PUT, 16'(i), 32'h8000_0000, 32'(i));
    send_req(REQ_FLUSH);
    send_req(REQ_TAKE);
  endtask

  // Zero pixel rate gives an all-ones reference time; zero scale pins it at 0
  task automatic test_rate_extremes();
    write_reg(CFG_PIXEL_RATE, 32'd0);
    send_req(REQ_READ);
    send_req(REQ_TICK);
    write_reg(CFG_FRAME_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_PIXEL_RATE, 32'd1);
    send_req(REQ_TICK);
    send_req(REQ_READ);
    write_reg(CFG_FRAME_SCALE, 32'd0);
    write_reg(CFG_PIXEL_RATE, 32'hFFFF_FFFF);
    send_req(REQ_TICK);
    send_req(REQ_FLUSH);
    for (int i = 0; i < FRAMES + 1; i++) send_req(REQ_TAKE);
  endtask

  // Well-formed traffic: frames stamped around the upcoming ticks, mixed with noise
  task automatic test_random(int n_items, logic [31:0] scale, logic [31:0] rate);
    logic [31:0] base;
    fps_req_t r;
    write_reg(CFG_FRAME_SCALE, scale);
    write_reg(CFG_PIXEL_RATE, rate);
    for (int i = 0; i < n_items; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      base = ref_time_at(vcount_m);
      r.id   = 16'($urandom);
      r.addr = $urandom;
      r.req  = REQ_READ;
      r.stamp = $urandom;
      if (pick < 35) begin
        r.req = REQ_PUT;
        if ($urandom_range(0, 4) != 0)
          r.stamp = base + 32'($signed($urandom_range(0, 6 * (scale / (rate | 1) + 1))))
                    - 32'(scale / (rate | 1));
      end else if (pick < 65) r.req = REQ_TICK;
      else if (pick < 88) r.req = REQ_TAKE;
      else if (pick < 91) r.req = REQ_FLUSH;
      else if (pick < 96) r.req = REQ_READ;
      else r.req = 3'($urandom_range(5, 7));
      send_item(r);
      if (i == n_items / 2) drain_results();   // sender holds until all results in
    end
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= '0;
    in_ch.frame_id      <= '0;
    in_ch.frame_time    <= '0;
    in_ch.frame_address <= '0;
    scale_m = 32'd0; rate_m = 32'd1; vcount_m = '0; slot_ok_m = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_rate_extremes();
    test_random(300, 32'd1000, 32'd100);
    test_random(200, 32'd640000, 32'd3);
    test_random(150, 32'd4000, 32'd4000);
    // last stretch runs at full rate on both sides
    drain_results();
    src_gap_en = 1'b0;
    sink_stall_en = 1'b0;
    test_random(200, 32'd7, 32'd2);
    drain_results();

    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
